// ----- design/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the moisture pump controller
// Configuration record, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE          = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUMP_INTERVAL   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRY_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WARMUP_READINGS = 3'd4;

  // reset values
  localparam logic [15:0] SENSOR_INTERVAL_RST = 16'd30000;
  localparam logic [15:0] PUMP_INTERVAL_RST   = 16'd10000;
  localparam logic [6:0]  DRY_THRESHOLD_RST   = 7'd25;
  localparam logic [3:0]  WARMUP_READINGS_RST = 4'd5;
  localparam int          LOWEST_RST          = 3000;
  localparam int          HIGHEST_RST         = 1000;

  localparam logic [3:0]  COUNT_MAX = 4'd15;
  localparam logic [6:0]  PCT_MAX   = 7'd100;

  typedef struct packed {
    logic        enable;
    logic [15:0] sensor_interval;
    logic [15:0] pump_interval;
    logic [6:0]  dry_threshold;
    logic [3:0]  warmup_readings;
  } cfg_t;

endpackage

// ----- design/mpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mpc_cfg_regs: configuration register file
// Takes register writes by index and presents them as one record.
// ----------------------------------------------------------------------------
module mpc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mpc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output mpc_pkg::cfg_t                    cfg
);

  mpc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b0;
      cfg_r.sensor_interval <= mpc_pkg::SENSOR_INTERVAL_RST;
      cfg_r.pump_interval   <= mpc_pkg::PUMP_INTERVAL_RST;
      cfg_r.dry_threshold   <= mpc_pkg::DRY_THRESHOLD_RST;
      cfg_r.warmup_readings <= mpc_pkg::WARMUP_READINGS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpc_pkg::CFG_ENABLE:          cfg_r.enable          <= cfg_data[0];
        mpc_pkg::CFG_SENSOR_INTERVAL: cfg_r.sensor_interval <= cfg_data;
        mpc_pkg::CFG_PUMP_INTERVAL:   cfg_r.pump_interval   <= cfg_data;
        mpc_pkg::CFG_DRY_THRESHOLD:   cfg_r.dry_threshold   <= cfg_data[6:0];
        mpc_pkg::CFG_WARMUP_READINGS: cfg_r.warmup_readings <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/mpc_divider.sv -----
// ----------------------------------------------------------------------------
// mpc_divider: serial percent divider
// Restoring divide of unsigned magnitudes, one compare-subtract a cycle,
// quotient clamped to 100.
// ----------------------------------------------------------------------------
module mpc_divider #(
  parameter int MAG_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MAG_BITS+6:0]   dividend,
  input  logic [MAG_BITS-1:0]   divisor,
  output logic                  done,
  output logic [6:0]            quotient
);

  localparam int DW = MAG_BITS + 7;
  localparam logic [2:0] LAST_STEP = 3'd6;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t       state_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsh_r;
  logic [5:0]    q_r;
  logic [2:0]    step_r;
  logic          done_r;
  logic [6:0]    quot_r;

  logic          fits;
  logic [DW-1:0] rem_sub;
  logic [6:0]    q_full;

  assign fits    = (rem_r >= dsh_r);
  assign rem_sub = rem_r - dsh_r;
  assign q_full  = {q_r, fits};

  assign done     = done_r;
  assign quotient = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            // quotient of 128 or more saturates straight away
            if (dividend >= {divisor, 7'b0}) begin
              quot_r <= mpc_pkg::PCT_MAX;
              done_r <= 1'b1;
            end else begin
              rem_r   <= dividend;
              dsh_r   <= {1'b0, divisor, 6'b0};
              q_r     <= '0;
              step_r  <= '0;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (fits) rem_r <= rem_sub;
          dsh_r  <= dsh_r >> 1;
          q_r    <= q_full[5:0];
          step_r <= step_r + 3'd1;
          if (step_r == LAST_STEP) begin
            quot_r  <= (q_full > mpc_pkg::PCT_MAX) ? mpc_pkg::PCT_MAX : q_full;
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- design/moisture_pump_controller.sv -----
// ----------------------------------------------------------------------------
// moisture_pump_controller: soil moisture sampler and pump switch
// One item per millisecond tick; forces the pump off on its own interval,
// samples on another, tracks extremes and maps the sample to a percent.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in_     | input     | in_valid / in_stall | in_adc_sample
//   out_    | output    | out_valid/out_stall | pump_on, events, moisture ...
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item with no reading to compute (disabled, no sample, warm-up) goes from
// accept to ST_FINISH; equal extremes or a zero or negative ratio pass ST_PREP
// first, and others also wait in ST_DIV for seven compare-subtract steps of the
// serial divider; the next item can be taken in the cycle after the load.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled output holds that result and delays only the next load.
// Reset is synchronous: all counters, extremes and the pump level return to
// their start values. cfg_ready is always high.
// ----------------------------------------------------------------------------
module moisture_pump_controller #(
  parameter int ADC_BITS        = 12,
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADC_BITS-1:0]              in_adc_sample,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pump_on,
  output logic                             out_pump_off_event,
  output logic                             out_pump_on_event,
  output logic                             out_sample_taken,
  output logic                             out_moisture_valid,
  output logic [6:0]                       out_moisture,
  output logic [ADC_BITS-1:0]              out_raw_value,
  output logic                             out_new_min,
  output logic                             out_new_max,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  // extremes are kept wide enough for their reset values
  localparam int EXT_BITS = (ADC_BITS > 12) ? ADC_BITS : 12;
  localparam int TW       = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
  localparam int DW       = EXT_BITS + 7;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV, ST_FINISH} state_t;

  mpc_pkg::cfg_t cfg;

  mpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer and controller state
  state_t                     state_r, state_nxt;
  logic [TICK_COUNT_BITS-1:0] pc_cnt_r, pc_cnt_nxt;
  logic [TICK_COUNT_BITS-1:0] smp_cnt_r, smp_cnt_nxt;
  logic                       pc_started_r, pc_started_nxt;
  logic                       smp_started_r, smp_started_nxt;
  logic [EXT_BITS-1:0]        low_r, low_nxt;
  logic [EXT_BITS-1:0]        high_r, high_nxt;
  logic [3:0]                 count_r, count_nxt;
  logic                       pump_r, pump_nxt;

  // per-item working fields
  logic                       off_ev_r, off_ev_nxt;
  logic                       taken_r, taken_nxt;
  logic                       mvalid_r, mvalid_nxt;
  logic                       nmin_r, nmin_nxt;
  logic                       nmax_r, nmax_nxt;
  logic [ADC_BITS-1:0]        raw_r, raw_nxt;
  logic [6:0]                 moist_r, moist_nxt;
  logic                       div_start_r, div_start_nxt;
  logic [DW-1:0]              dividend_r, dividend_nxt;
  logic [EXT_BITS-1:0]        divisor_r, divisor_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic                       o_pump_r, o_pump_nxt;
  logic                       o_off_r, o_off_nxt;
  logic                       o_on_r, o_on_nxt;
  logic                       o_taken_r, o_taken_nxt;
  logic                       o_mvalid_r, o_mvalid_nxt;
  logic [6:0]                 o_moist_r, o_moist_nxt;
  logic [ADC_BITS-1:0]        o_raw_r, o_raw_nxt;
  logic                       o_nmin_r, o_nmin_nxt;
  logic                       o_nmax_r, o_nmax_nxt;

  logic                       div_done;
  logic [6:0]                 div_quot;

  // combinational helpers
  logic                       in_acc;
  logic [TICK_COUNT_BITS-1:0] pc_inc, smp_inc;
  logic                       pc_fire, smp_fire;
  logic [EXT_BITS-1:0]        raw_ext;
  logic                       warm;
  logic [3:0]                 count_up;
  logic signed [EXT_BITS:0]   num_s, den_s, num_neg, den_neg;
  logic [EXT_BITS-1:0]        num_mag, den_mag;
  logic                       on_ev;

  mpc_divider #(.MAG_BITS(EXT_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dividend_r),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // saturating tick counters, advanced before the interval compare
  assign pc_inc  = pc_started_r
                 ? ((&pc_cnt_r) ? pc_cnt_r : pc_cnt_r + 1'b1) : pc_cnt_r;
  assign smp_inc = smp_started_r
                 ? ((&smp_cnt_r) ? smp_cnt_r : smp_cnt_r + 1'b1) : smp_cnt_r;
  assign pc_fire  = !pc_started_r
                 || (TW'(pc_inc) >= TW'(cfg.pump_interval));
  assign smp_fire = !smp_started_r
                 || (TW'(smp_inc) >= TW'(cfg.sensor_interval));

  assign raw_ext  = EXT_BITS'(in_adc_sample);
  assign warm     = (count_r >= cfg.warmup_readings);
  assign count_up = (count_r < mpc_pkg::COUNT_MAX) ? count_r + 4'd1 : count_r;

  // signed numerator and denominator from the updated extremes
  assign num_s   = $signed({1'b0, EXT_BITS'(raw_r)}) - $signed({1'b0, high_r});
  assign den_s   = $signed({1'b0, low_r}) - $signed({1'b0, high_r});
  assign num_neg = -num_s;
  assign den_neg = -den_s;
  assign num_mag = num_s[EXT_BITS] ? num_neg[EXT_BITS-1:0] : num_s[EXT_BITS-1:0];
  assign den_mag = den_s[EXT_BITS] ? den_neg[EXT_BITS-1:0] : den_s[EXT_BITS-1:0];

  assign on_ev = mvalid_r && (moist_r < cfg.dry_threshold);

  always_comb begin
    state_nxt       = state_r;
    pc_cnt_nxt      = pc_cnt_r;
    smp_cnt_nxt     = smp_cnt_r;
    pc_started_nxt  = pc_started_r;
    smp_started_nxt = smp_started_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    count_nxt       = count_r;
    pump_nxt        = pump_r;
    off_ev_nxt      = off_ev_r;
    taken_nxt       = taken_r;
    mvalid_nxt      = mvalid_r;
    nmin_nxt        = nmin_r;
    nmax_nxt        = nmax_r;
    raw_nxt         = raw_r;
    moist_nxt       = moist_r;
    div_start_nxt   = 1'b0;
    dividend_nxt    = dividend_r;
    divisor_nxt     = divisor_r;
    out_valid_nxt   = out_valid_r && out_stall;
    o_pump_nxt      = o_pump_r;
    o_off_nxt       = o_off_r;
    o_on_nxt        = o_on_r;
    o_taken_nxt     = o_taken_r;
    o_mvalid_nxt    = o_mvalid_r;
    o_moist_nxt     = o_moist_r;
    o_raw_nxt       = o_raw_r;
    o_nmin_nxt      = o_nmin_r;
    o_nmax_nxt      = o_nmax_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // time passes even while disabled
          pc_cnt_nxt  = pc_inc;
          smp_cnt_nxt = smp_inc;
          off_ev_nxt  = 1'b0;
          taken_nxt   = 1'b0;
          mvalid_nxt  = 1'b0;
          nmin_nxt    = 1'b0;
          nmax_nxt    = 1'b0;
          raw_nxt     = '0;
          moist_nxt   = '0;
          state_nxt   = ST_FINISH;
          if (cfg.enable) begin
            if (pc_fire) begin
              pc_started_nxt = 1'b1;
              pc_cnt_nxt     = '0;
              pump_nxt       = 1'b0;
              off_ev_nxt     = 1'b1;
            end
            if (smp_fire) begin
              smp_started_nxt = 1'b1;
              smp_cnt_nxt     = '0;
              taken_nxt       = 1'b1;
              if (raw_ext < low_r) begin
                low_nxt  = raw_ext;
                nmin_nxt = warm;
              end
              if (raw_ext > high_r) begin
                high_nxt = raw_ext;
                nmax_nxt = warm;
              end
              count_nxt = count_up;
              if (count_up >= cfg.warmup_readings) begin
                mvalid_nxt = 1'b1;
                raw_nxt    = in_adc_sample;
                state_nxt  = ST_PREP;
              end
            end
          end
        end
      end
      ST_PREP: begin
        priority if (den_s == '0) begin
          // equal extremes read as fully wet
          moist_nxt = mpc_pkg::PCT_MAX;
          state_nxt = ST_FINISH;
        end else if ((num_s == '0) || (num_s[EXT_BITS] != den_s[EXT_BITS])) begin
          // zero or negative ratio clamps to 0
          moist_nxt = '0;
          state_nxt = ST_FINISH;
        end else begin
          dividend_nxt  = DW'(num_mag) * DW'(mpc_pkg::PCT_MAX);
          divisor_nxt   = den_mag;
          div_start_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          moist_nxt = div_quot;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          pump_nxt      = pump_r | on_ev;
          out_valid_nxt = 1'b1;
          o_pump_nxt    = pump_r | on_ev;
          o_off_nxt     = off_ev_r;
          o_on_nxt      = on_ev;
          o_taken_nxt   = taken_r;
          o_mvalid_nxt  = mvalid_r;
          o_moist_nxt   = moist_r;
          o_raw_nxt     = raw_r;
          o_nmin_nxt    = nmin_r;
          o_nmax_nxt    = nmax_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pc_cnt_r      <= '0;
      smp_cnt_r     <= '0;
      pc_started_r  <= 1'b0;
      smp_started_r <= 1'b0;
      low_r         <= EXT_BITS'(mpc_pkg::LOWEST_RST);
      high_r        <= EXT_BITS'(mpc_pkg::HIGHEST_RST);
      count_r       <= '0;
      pump_r        <= 1'b0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pc_cnt_r      <= pc_cnt_nxt;
      smp_cnt_r     <= smp_cnt_nxt;
      pc_started_r  <= pc_started_nxt;
      smp_started_r <= smp_started_nxt;
      low_r         <= low_nxt;
      high_r        <= high_nxt;
      count_r       <= count_nxt;
      pump_r        <= pump_nxt;
      div_start_r   <= div_start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    off_ev_r   <= off_ev_nxt;
    taken_r    <= taken_nxt;
    mvalid_r   <= mvalid_nxt;
    nmin_r     <= nmin_nxt;
    nmax_r     <= nmax_nxt;
    raw_r      <= raw_nxt;
    moist_r    <= moist_nxt;
    dividend_r <= dividend_nxt;
    divisor_r  <= divisor_nxt;
    o_pump_r   <= o_pump_nxt;
    o_off_r    <= o_off_nxt;
    o_on_r     <= o_on_nxt;
    o_taken_r  <= o_taken_nxt;
    o_mvalid_r <= o_mvalid_nxt;
    o_moist_r  <= o_moist_nxt;
    o_raw_r    <= o_raw_nxt;
    o_nmin_r   <= o_nmin_nxt;
    o_nmax_r   <= o_nmax_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_pump_on        = o_pump_r;
  assign out_pump_off_event = o_off_r;
  assign out_pump_on_event  = o_on_r;
  assign out_sample_taken   = o_taken_r;
  assign out_moisture_valid = o_mvalid_r;
  assign out_moisture       = o_moist_r;
  assign out_raw_value      = o_raw_r;
  assign out_new_min        = o_nmin_r;
  assign out_new_max        = o_nmax_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block took no time after an accepted item");

  a_moisture_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_moisture <= mpc_pkg::PCT_MAX))
    else $error("moisture above 100 percent");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_moisture_valid) |-> (out_moisture == '0 && out_raw_value == '0))
    else $error("moisture fields set without a valid reading");

  a_on_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pump_on_event) |-> out_pump_on)
    else $error("pump switched on but level low");

  a_extreme_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_new_min || out_new_max)) |-> out_sample_taken)
    else $error("extreme flagged without a sample");
`endif

endmodule
